FILE: rtl/irpd_pkg.sv
`default_nettype none

package irpd_pkg;

  // Frame geometry and pattern table size.
  localparam int NUM_BITS     = 12;
  localparam int IDX_W        = 4;   // holds 0..NUM_BITS
  localparam int NUM_PATTERNS = 25;
  localparam int KEY_W        = 4;
  localparam int THR_W        = 32;

  // Frame phase codes.
  localparam logic [1:0] PHASE_RESET = 2'd1;
  localparam logic [1:0] PHASE_BITS  = 2'd2;
  localparam logic [1:0] PHASE_END   = 2'd3;
  localparam logic [1:0] PHASE_IDLE  = 2'd0;

  // Register indexes on the configuration port (word address).
  localparam logic REG_BIT_THR = 1'b0;
  localparam logic REG_GAP_THR = 1'b1;

  localparam logic [THR_W-1:0] BIT_THR_RESET = 32'd200000;
  localparam logic [THR_W-1:0] GAP_THR_RESET = 32'd7000000;

  typedef logic [NUM_BITS-1:0] pattern_t;

  // Button patterns; two rows per key, key code is row / 2.
  localparam pattern_t PATTERN_TABLE [NUM_PATTERNS] = '{
    12'h002, 12'h004, 12'h802, 12'h804, 12'hC02, 12'hC04, 12'h404, 12'h402,
    12'h602, 12'h604, 12'h602, 12'h604, 12'h204, 12'h202, 12'h204, 12'h202,
    12'h302, 12'h304, 12'h702, 12'h704, 12'h702, 12'h502, 12'h504, 12'h0C4,
    12'h2C2
  };

  // Frame tracker status toward the top level.
  typedef struct packed {
    logic     frame_end;   // the item under work closes a frame
    pattern_t bits;        // bits received so far
  } irpd_frame_t;

endpackage

`default_nettype wire

FILE: rtl/irpd_frame.sv
`default_nettype none

module irpd_frame (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     step,
  input  wire logic [irpd_pkg::THR_W-1:0] interval,
  input  wire logic [irpd_pkg::THR_W-1:0] bit_thr,
  input  wire logic [irpd_pkg::THR_W-1:0] gap_thr,
  output irpd_pkg::irpd_frame_t         status
);
  import irpd_pkg::*;

  logic [1:0]       frame_phase, frame_phase_next;
  logic [IDX_W-1:0] bit_index, bit_index_next;
  pattern_t         received_bits, received_bits_next;

  logic above_bit, below_bit, above_gap, below_gap;
  logic store_one, store_zero, advance, frame_end;
  logic [1:0] phase_inc;

  assign above_bit = interval > bit_thr;
  assign below_bit = interval < bit_thr;
  assign above_gap = interval > gap_thr;
  assign below_gap = interval < gap_thr;

  // First matching test wins: one bit, zero bit, then frame gap.
  assign store_one  = above_bit && below_gap && (frame_phase == PHASE_BITS);
  assign store_zero = !store_one && below_bit && (frame_phase == PHASE_BITS);
  assign advance    = !store_one && !store_zero && above_gap;
  assign phase_inc  = frame_phase + 2'd1;
  assign frame_end  = advance && (phase_inc == PHASE_END);

  always_comb begin
    frame_phase_next   = frame_phase;
    bit_index_next     = bit_index;
    received_bits_next = received_bits;
    if (store_one || store_zero) begin
      if (bit_index < IDX_W'(NUM_BITS)) begin
        for (int b = 0; b < NUM_BITS; b++) begin
          if (bit_index == IDX_W'(b)) begin
            received_bits_next[b] = store_one;
          end
        end
        bit_index_next = bit_index + IDX_W'(1);
      end
    end else if (frame_end) begin
      frame_phase_next = PHASE_IDLE;
      bit_index_next   = '0;
    end else if (advance) begin
      frame_phase_next = phase_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_phase   <= PHASE_RESET;
      bit_index     <= '0;
      received_bits <= '0;
    end else if (step) begin
      frame_phase   <= frame_phase_next;
      bit_index     <= bit_index_next;
      received_bits <= received_bits_next;
    end
  end

  assign status.frame_end = frame_end;
  assign status.bits      = received_bits;

endmodule

`default_nettype wire

FILE: rtl/irpd_match.sv
`default_nettype none

module irpd_match (
  input  wire logic [irpd_pkg::NUM_BITS-1:0] bits,
  output logic                             matched,
  output logic [irpd_pkg::KEY_W-1:0]       key_code
);
  import irpd_pkg::*;

  // Scan from the last row down so that the lowest matching row wins.
  always_comb begin
    matched  = 1'b0;
    key_code = '0;
    for (int r = NUM_PATTERNS - 1; r >= 0; r--) begin
      if (PATTERN_TABLE[r] == bits) begin
        matched  = 1'b1;
        key_code = KEY_W'(r >> 1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ir_pulse_distance_key_decoder.sv
`default_nettype none
// Path: an interval beat sits in the input register while the frame tracker works
// on it; a beat that closes a frame then loads the result register. Throughput: one
// beat per cycle, except while a frame-closing beat waits on a full result register.
// Reset (rst, synchronous, active high): frame phase 1, bit index 0, received
// bits cleared, thresholds back to 200000 and 7000000, no result pending.

module ir_pulse_distance_key_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream: tdata[31:0] = interval.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,
  // Result stream: tdata[0] = matched, tdata[4:1] = key_code, tdata[7:5] = 0.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,
  // Configuration port: 0x0 bit threshold, 0x4 gap threshold.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import irpd_pkg::*;

  // Threshold registers. The word address is paddr[2]; byte offsets are ignored.
  logic [THR_W-1:0] bit_thr, gap_thr;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_thr <= BIT_THR_RESET;
      gap_thr <= GAP_THR_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_BIT_THR) begin
        bit_thr <= pwdata;
      end else begin
        gap_thr <= pwdata;
      end
    end
  end

  assign prdata = (paddr[2] == REG_BIT_THR) ? bit_thr : gap_thr;

  // Input register: holds one interval beat while the frame tracker works on it.
  logic             s1_valid;
  logic [THR_W-1:0] s1_interval;
  logic             retire;
  logic             out_free;
  irpd_frame_t      frame;

  // The result register may load when it is empty or being drained this cycle.
  // A beat that closes no frame never needs it, so it retires unconditionally.
  assign out_free = !m_tvalid || m_tready;
  assign retire   = s1_valid && (!frame.frame_end || out_free);
  assign s_tready = !s1_valid || retire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_interval <= s_tdata;
    end
  end

  // Frame tracker: classifies the interval and updates phase, index and bits.
  irpd_frame u_frame (
    .clk      (clk),
    .rst      (rst),
    .step     (retire),
    .interval (s1_interval),
    .bit_thr  (bit_thr),
    .gap_thr  (gap_thr),
    .status   (frame)
  );

  // The gap beat that closes a frame stores no bit, so the current bits are final.
  logic             match_hit;
  logic [KEY_W-1:0] match_key;

  irpd_match u_match (
    .bits     (frame.bits),
    .matched  (match_hit),
    .key_code (match_key)
  );

  // Result register.
  logic             out_valid;
  logic             out_matched;
  logic [KEY_W-1:0] out_key;
  logic             out_load;

  assign out_load = retire && frame.frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_matched <= match_hit;
      out_key     <= match_key;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_key, out_matched};

endmodule

`default_nettype wire

FILE: rtl/irpd_checker.sv
`default_nettype none

module irpd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [7:0]  m_tdata
);

  // No result may be pending right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending after reset");

  // With the result register empty, the input side is never stalled.
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while result register empty");

  // A no-match result carries key code zero, and key codes stay in range.
  a_key_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] || m_tdata[4:1] == 4'd0) && m_tdata[4:1] <= 4'd12
      && m_tdata[7:5] == 3'd0)
    else $error("bad result beat");

  // A stalled result beat stays valid.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

endmodule

bind ir_pulse_distance_key_decoder irpd_checker u_irpd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: verif/irpd_tb_pkg.sv
`default_nettype none

package irpd_tb_pkg;

  import irpd_pkg::*;

  // Own copy of the button patterns, so that a wrong table in the design shows up.
  localparam pattern_t KEY_PATTERNS [NUM_PATTERNS] = '{
    12'h002, 12'h004, 12'h802, 12'h804, 12'hC02, 12'hC04, 12'h404, 12'h402,
    12'h602, 12'h604, 12'h602, 12'h604, 12'h204, 12'h202, 12'h204, 12'h202,
    12'h302, 12'h304, 12'h702, 12'h704, 12'h702, 12'h502, 12'h504, 12'h0C4,
    12'h2C2
  };

  typedef struct packed {
    logic             matched;
    logic [KEY_W-1:0] key_code;
  } key_result_t;

  // Tracks the frame state of the decoder and the key results still owed by it.
  class keypress_tracker;
    logic [THR_W-1:0] bit_thr;
    logic [THR_W-1:0] gap_thr;
    logic [1:0]       phase;
    int unsigned      bit_idx;
    pattern_t         bits;
    key_result_t      pending_keys [$];
    int unsigned      items_accepted;
    int unsigned      effective_items;
    int unsigned      keys_predicted;
    int unsigned      keys_checked;
    int unsigned      keys_matched;
    int unsigned      errors;

    function new();
      bit_thr = BIT_THR_RESET;
      gap_thr = GAP_THR_RESET;
      phase   = PHASE_RESET;
      bit_idx = 0;
      bits    = '0;
    endfunction

    function int unsigned pending();
      return pending_keys.size();
    endfunction

    // Bits past the end of the frame are dropped.
    function void store_bit(logic value);
      if (bit_idx < NUM_BITS) begin
        bits[bit_idx] = value;
        bit_idx++;
      end
    endfunction

    function void note_interval(logic [THR_W-1:0] iv);
      key_result_t key;
      int unsigned row;
      items_accepted++;
      // The one-bit test comes first, then the zero-bit test, then the gap test.
      if (iv > bit_thr && iv < gap_thr && phase == PHASE_BITS) begin
        store_bit(1'b1);
      end else if (iv < bit_thr && phase == PHASE_BITS) begin
        store_bit(1'b0);
      end else if (iv > gap_thr) begin
        phase = phase + 2'd1;
        if (phase == PHASE_END) begin
          phase   = PHASE_IDLE;
          bit_idx = 0;
          key     = '0;
          for (row = 0; row < NUM_PATTERNS && !key.matched; row++) begin
            if (KEY_PATTERNS[row] == bits) begin
              key.matched  = 1'b1;
              key.key_code = KEY_W'(row / 2);
            end
          end
          pending_keys.push_back(key);
          keys_predicted++;
        end
      end else begin
        return;
      end
      effective_items++;
    endfunction

    task report(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("MISMATCH %s: expected 0x%0h, got 0x%0h", what, want, got);
    endtask

    task check_key(logic [7:0] data);
      key_result_t want;
      if (pending_keys.size() == 0) begin
        report("key result with none outstanding", 32'd0, data);
        return;
      end
      want = pending_keys.pop_front();
      keys_checked++;
      if (want.matched) keys_matched++;
      if (data[0] !== want.matched) report("matched", want.matched, data[0]);
      if (data[4:1] !== want.key_code) report("key_code", want.key_code, data[4:1]);
      if (data[7:5] !== 3'b000) report("result padding", 32'd0, data[7:5]);
    endtask
  endclass

endpackage

`default_nettype wire

FILE: verif/tb_top.sv
`default_nettype none

// Stream-level test of the IR key decoder. Interval beats go in on the slave
// side; every third gap from an idle frame phase closes a frame and produces one
// key beat on the master side. A tracker object follows the frame state for
// every accepted interval and queues the key it expects; each key beat that
// leaves the block is checked against the oldest queued key.
module tb_top;

  import irpd_pkg::*;
  import irpd_tb_pkg::*;

  // Byte addresses of the two threshold registers.
  localparam logic [2:0] ADDR_BIT_THR = 3'h0;
  localparam logic [2:0] ADDR_GAP_THR = 3'h4;

  // Settling margin after the owed keys, for beats still in the pipe.
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 400000;

  // What an interval should look like relative to the current thresholds.
  typedef enum int {IV_ZERO, IV_ONE, IV_GAP, IV_AT_BIT, IV_AT_GAP, IV_ANY} iv_kind_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;      // [31:0] interval
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;      // [0] matched, [4:1] key_code, [7:5] zero
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  keypress_tracker board;

  // Per-phase idling switches for the two sides, and the length of a forced
  // receiver hold-off requested by the main sequence.
  bit          tx_idle;
  bit          rx_idle;
  int unsigned hold_len;
  int unsigned settings_used;
  int unsigned cycles;

  ir_pulse_distance_key_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake or a key that never arrives ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d keys outstanding", cycles, board.pending());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Every key beat accepted at a rising edge is checked against the oldest
  // expectation. Values are read before the design updates them at this edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_key(m_tdata);
  end

  // Receiver. Before each beat it stalls for a random number of cycles (when
  // idling is enabled), then holds tready high until a beat goes through. A
  // hold-off request from the main sequence breaks in and is counted out here.
  initial begin
    int unsigned stall;
    m_tready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (hold_len != 0) begin
        stall    = hold_len;
        hold_len = 0;
      end else begin
        stall = rx_idle ? $urandom_range(16, 0) : 0;
      end
      if (stall != 0) begin
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid && hold_len == 0);
    end
  end

  // One interval beat: optional idle gap, then offer the beat until accepted.
  // tvalid stays high between back-to-back beats; it is lowered only for an idle gap.
  task automatic send_interval(logic [31:0] value);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(16, 0) : 0;
    if (gap != 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    board.note_interval(value);
  endtask

  // Stop sending and wait for every owed key, then let the pipe settle so a
  // beat that produces no key is fully absorbed before registers change.
  task automatic wait_drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(logic write, logic [2:0] addr, logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write a threshold, read it back, and update the tracker's copy.
  task automatic set_threshold(logic [2:0] addr, logic [31:0] value);
    logic [31:0] rb;
    apb_access(1'b1, addr, value, rb);
    apb_access(1'b0, addr, 32'd0, rb);
    if (rb !== value) board.report("threshold readback", value, rb);
    if (addr == ADDR_BIT_THR) board.bit_thr = value;
    else board.gap_thr = value;
    settings_used++;
  endtask

  // Picks an interval of the requested class under the current thresholds,
  // with a bias toward the values right next to a threshold. Where the class
  // cannot exist (for example no count lies above an all-ones threshold), a
  // count equal to a threshold is returned, which the decoder ignores unless the thresholds are crossed.
  function automatic logic [31:0] make_interval(iv_kind_t kind);
    logic [31:0] lo;
    logic [31:0] hi;
    int unsigned pick;
    lo   = board.bit_thr;
    hi   = board.gap_thr;
    pick = $urandom_range(3, 0);
    case (kind)
      IV_ZERO: begin
        if (lo == 0) return lo;
        if (pick == 0) return 32'd0;
        if (pick == 1) return lo - 1;
        return $urandom_range(lo - 1, 0);
      end
      IV_ONE: begin
        if ({1'b0, hi} <= {1'b0, lo} + 33'd1) return lo;
        if (pick == 0) return lo + 1;
        if (pick == 1) return hi - 1;
        return $urandom_range(hi - 1, lo + 1);
      end
      IV_GAP: begin
        if (hi == 32'hFFFF_FFFF) return hi;
        if (pick == 0) return hi + 1;
        if (pick == 1) return 32'hFFFF_FFFF;
        return $urandom_range(32'hFFFF_FFFF, hi + 1);
      end
      IV_AT_BIT: return lo;
      IV_AT_GAP: return hi;
      default:   return $urandom;
    endcase
  endfunction

  // A frame: gaps until the bit phase opens (at most three), the data bits
  // with threshold-equal noise mixed in, and a closing gap. Bits beyond the
  // twelfth are random and should be dropped by the decoder.
  task automatic send_frame(pattern_t pattern, int unsigned nbits, int unsigned noise_pct);
    logic [15:0] bit_src;
    int unsigned tries;
    int unsigned b;
    bit_src = {4'($urandom), pattern};
    for (tries = 0; tries < 3 && board.phase != PHASE_BITS; tries++) begin
      send_interval(make_interval(IV_GAP));
    end
    for (b = 0; b < nbits; b++) begin
      if ($urandom_range(99, 0) < noise_pct) begin
        send_interval(make_interval(($urandom_range(1, 0) != 0) ? IV_AT_BIT : IV_AT_GAP));
      end
      send_interval(make_interval(bit_src[b] ? IV_ONE : IV_ZERO));
    end
    send_interval(make_interval(IV_GAP));
  endtask

  // Random traffic under the current settings. Mostly well-formed frames with
  // table patterns or random bits; the rest short or long frames and loose
  // intervals of any class. Runs until enough state-changing beats and keys
  // have been produced, or the raw beat cap is hit.
  task automatic run_random(int unsigned item_goal, int unsigned key_goal,
                            int unsigned raw_cap);
    int unsigned eff0;
    int unsigned key0;
    int unsigned raw0;
    int unsigned roll;
    eff0 = board.effective_items;
    key0 = board.keys_predicted;
    raw0 = board.items_accepted;
    while ((board.effective_items - eff0 < item_goal || board.keys_predicted - key0 < key_goal)
           && board.items_accepted - raw0 < raw_cap) begin
      roll = $urandom_range(99, 0);
      if (roll < 45) begin
        send_frame(KEY_PATTERNS[$urandom_range(NUM_PATTERNS - 1, 0)], NUM_BITS, 5);
      end else if (roll < 70) begin
        send_frame(pattern_t'($urandom), NUM_BITS, 10);
      end else if (roll < 85) begin
        send_frame(pattern_t'($urandom), $urandom_range(16, 0), 20);
      end else begin
        repeat ($urandom_range(6, 1)) send_interval(make_interval(iv_kind_t'($urandom_range(5, 0))));
      end
    end
    wait_drain();
  endtask

  // Gap beats back to back while the receiver is held off: a key waits in the result
  // register, and the next frame-closing gap makes the block stop taking intervals.
  task automatic flood_with_gaps();
    int unsigned n;
    hold_len = 300;
    for (n = 0; n < 36; n++) send_interval(make_interval(IV_GAP));
    wait_drain();
  endtask

  initial begin
    logic [31:0] rb;
    int unsigned k;
    logic [31:0] bt;

    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    hold_len = 0;
    tx_idle  = 1'b1;
    rx_idle  = 1'b1;
    board    = new();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Thresholds must come out of reset at their documented values.
    apb_access(1'b0, ADDR_BIT_THR, 32'd0, rb);
    if (rb !== BIT_THR_RESET) board.report("bit threshold after reset", BIT_THR_RESET, rb);
    apb_access(1'b0, ADDR_GAP_THR, 32'd0, rb);
    if (rb !== GAP_THR_RESET) board.report("gap threshold after reset", GAP_THR_RESET, rb);

    // Directed frames at the reset thresholds. The phase starts at one, so a
    // single gap opens the first bit phase.
    send_interval(32'd0);                  // zero-bit count outside the bit phase: ignored
    send_interval(GAP_THR_RESET);          // exactly at the gap threshold: ignored
    send_interval(GAP_THR_RESET + 1);      // smallest gap: bit phase opens
    send_interval(BIT_THR_RESET - 1);      // bit 0 = 0, largest zero count
    send_interval(BIT_THR_RESET + 1);      // bit 1 = 1, smallest one count
    send_interval(BIT_THR_RESET);          // exactly at the bit threshold: ignored
    for (k = 0; k < 10; k++) send_interval(k);   // bits 2..11 = 0
    send_interval(GAP_THR_RESET - 1);      // thirteenth bit, largest one count: dropped
    send_interval(32'hFFFF_FFFF);          // frame end on 12'h002: first key
    send_interval(GAP_THR_RESET + 1);      // idle phase to one
    send_interval(32'hFFFF_FFFF);          // bit phase again
    send_interval(GAP_THR_RESET - 1);      // only bit 0 rewritten; bit 1 keeps its one
    send_interval(32'h8000_0000);          // frame end on 12'h003: no match
    wait_drain();

    // Reset thresholds, both sides idling at random.
    run_random(80, 8, 1500);

    // Receiver held off while gaps stream in; then the sender waits it out.
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    flood_with_gaps();

    // Lowest thresholds: no count can be a zero or a one, only gaps act.
    tx_idle = 1'b1;
    set_threshold(ADDR_BIT_THR, 32'd0);
    set_threshold(ADDR_GAP_THR, 32'd1);
    run_random(20, 6, 400);

    // Bit threshold at all ones above the gap threshold: only zeros and the
    // all-ones count as a gap.
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    set_threshold(ADDR_BIT_THR, 32'hFFFF_FFFF);
    set_threshold(ADDR_GAP_THR, 32'hFFFF_FFFE);
    run_random(40, 8, 800);

    // Gap threshold at all ones: no frame can end, so no keys at all.
    rx_idle = 1'b0;
    set_threshold(ADDR_BIT_THR, 32'd1234567);
    set_threshold(ADDR_GAP_THR, 32'hFFFF_FFFF);
    run_random(25, 0, 25);

    // Crossed thresholds: counts between them store zeros in the bit phase
    // and advance the phase elsewhere.
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    set_threshold(ADDR_BIT_THR, 32'd5000000);
    set_threshold(ADDR_GAP_THR, 32'd100000);
    run_random(30, 5, 800);

    // Random thresholds, the last pair drawn over the full range in any order.
    for (k = 0; k < 3; k++) begin
      tx_idle = k[0];
      rx_idle = !k[0];
      bt = (k == 2) ? $urandom : $urandom_range(2000000, 1);
      set_threshold(ADDR_BIT_THR, bt);
      set_threshold(ADDR_GAP_THR, (k == 2) ? $urandom : bt + $urandom_range(20000000, 2));
      run_random(30, 4, 600);
    end

    // Back to the reset values with no idling on either side.
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    set_threshold(ADDR_BIT_THR, BIT_THR_RESET);
    set_threshold(ADDR_GAP_THR, GAP_THR_RESET);
    run_random(40, 6, 800);

    $display("Sent %0d interval beats (%0d changed decoder state) under %0d threshold writes.",
             board.items_accepted, board.effective_items, settings_used);
    $display("Checked %0d key beats: %0d matched a button pattern, %0d matched none.",
             board.keys_checked, board.keys_matched, board.keys_checked - board.keys_matched);
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/irpd_pkg.sv
rtl/irpd_frame.sv
rtl/irpd_match.sv
rtl/ir_pulse_distance_key_decoder.sv
rtl/irpd_checker.sv
verif/irpd_tb_pkg.sv
verif/tb_top.sv
